FILE: rtl/core/repeating_timer_table_assert.svh
// Assertion macros used by the checker of the repeating timer table.
`ifndef REPEATING_TIMER_TABLE_ASSERT_SVH
`define REPEATING_TIMER_TABLE_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define RTT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: property failed");

// Next-cycle implication, held off during reset.
`define RTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: property failed");

`endif

FILE: rtl/core/rtt_pkg.sv
// Types, codes and constants of the repeating timer table.
package rtt_pkg;

  // Table size limits
  localparam int unsigned NumTimers  = 16;
  localparam int unsigned MaxIdxW    = 8;
  localparam int unsigned MaxResults = 16;
  localparam int unsigned FireCntW   = $clog2(MaxResults + 1);

  // Field widths
  localparam int unsigned CmdW    = 2;
  localparam int unsigned IndexW  = 4;
  localparam int unsigned PeriodW = 32;
  localparam int unsigned TimeW   = 48;

  // Command codes
  localparam logic [CmdW-1:0] CmdSet  = 2'd0;
  localparam logic [CmdW-1:0] CmdKill = 2'd1;
  localparam logic [CmdW-1:0] CmdTick = 2'd2;

  // One command transfer
  typedef struct packed {
    logic [CmdW-1:0]    command;
    logic [IndexW-1:0]  timer_index;
    logic [PeriodW-1:0] interval_ms;
    logic [TimeW-1:0]   now_ms;
  } in_t;

  // One result transfer
  typedef struct packed {
    logic [IndexW-1:0] fired_index;
    logic              last_fired;
  } out_t;

  // Memory word of one timer entry
  typedef struct packed {
    logic [PeriodW-1:0] period;
    logic [TimeW-1:0]   due;
  } entry_t;

  // Sequencer to store
  typedef struct packed {
    logic               rd_en;
    logic [MaxIdxW-1:0] rd_addr;
    logic               wr_en;
    logic [MaxIdxW-1:0] wr_addr;
    entry_t             wr_data;
    logic               arm_set;
    logic               arm_clr;
    logic [MaxIdxW-1:0] arm_addr;
  } mem_req_t;

  // Store to sequencer, registered from a read in the cycle before
  typedef struct packed {
    logic   armed;
    entry_t data;
  } mem_rsp_t;

endpackage

FILE: rtl/core/repeating_timer_table.sv
// Top level of the repeating timer table.
// A command transfers when start is high and busy is low. Set and kill take
// the accept cycle only and busy stays low. A tick holds busy high while the
// scan reads one entry per cycle through the single read port of the timer
// memory, checks and writes back the last entry read, and then finishes. A new
// command can therefore follow a tick once busy is low again. Each fired timer
// shows on result_o for one cycle with result_strobe_o high, in ascending
// index order, at most 16 per tick; the final one carries last_fired and
// appears in the first cycle with busy low again. The receiver cannot stall
// results, so it must take every strobe. A tick with nothing due produces no
// result.
module repeating_timer_table #(
  parameter int unsigned NUM_TIMERS = rtt_pkg::NumTimers
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  rtt_pkg::in_t  item_i,
  output logic          result_strobe_o,
  output rtt_pkg::out_t result_o
);
  import rtt_pkg::*;

  mem_req_t mem_req;
  mem_rsp_t mem_rsp;

  // Command sequencer
  rtt_scan #(
    .NUM_TIMERS(NUM_TIMERS)
  ) u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_strobe_o(result_strobe_o),
    .result_o       (result_o),
    .req_o          (mem_req),
    .rsp_i          (mem_rsp)
  );

  // Timer entry store
  rtt_store #(
    .NUM_TIMERS(NUM_TIMERS)
  ) u_store (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mem_req),
    .rsp_o (mem_rsp)
  );

endmodule

FILE: rtl/core/rtt_store.sv
// Timer entry store: period/due memory plus armed flags.
module rtt_store #(
  parameter int unsigned NUM_TIMERS = rtt_pkg::NumTimers
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rtt_pkg::mem_req_t req_i,
  output rtt_pkg::mem_rsp_t rsp_o
);
  import rtt_pkg::*;

  localparam int unsigned IdxW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  entry_t                mem [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] armed_q;
  entry_t                rd_data_q;
  logic                  rd_armed_q;

  // Period/due memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr[IdxW-1:0]] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q  <= mem[req_i.rd_addr[IdxW-1:0]];
      rd_armed_q <= armed_q[req_i.rd_addr[IdxW-1:0]];
    end
  end

  // Armed flags, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= '0;
    end else if (req_i.arm_set) begin
      armed_q[req_i.arm_addr[IdxW-1:0]] <= 1'b1;
    end else if (req_i.arm_clr) begin
      armed_q[req_i.arm_addr[IdxW-1:0]] <= 1'b0;
    end
  end

  assign rsp_o.armed = rd_armed_q;
  assign rsp_o.data  = rd_data_q;

endmodule

FILE: rtl/core/rtt_scan.sv
// Command sequencer: set/kill writes and the read-modify-write tick scan.
module rtt_scan #(
  parameter int unsigned NUM_TIMERS = rtt_pkg::NumTimers
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  rtt_pkg::in_t      item_i,
  output logic              result_strobe_o,
  output rtt_pkg::out_t     result_o,
  output rtt_pkg::mem_req_t req_o,
  input  rtt_pkg::mem_rsp_t rsp_i
);
  import rtt_pkg::*;

  localparam int unsigned IdxW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned CntW = $clog2(NUM_TIMERS + 1);

  localparam logic [CntW-1:0] LastCnt = CntW'(NUM_TIMERS);

  // State codes
  localparam logic [0:0] StIdle = 1'b0;
  localparam logic [0:0] StScan = 1'b1;

  // Saturating now + period
  function automatic logic [TimeW-1:0] due_from(input logic [TimeW-1:0]   now,
                                                input logic [PeriodW-1:0] per);
    logic [TimeW:0] sum;
    sum = {1'b0, now} + (TimeW + 1)'(per);
    return sum[TimeW] ? {TimeW{1'b1}} : sum[TimeW-1:0];
  endfunction

  logic [0:0]          state_q, state_d;
  logic [CntW-1:0]     rd_cnt_q, rd_cnt_d;
  logic                vld_q, vld_d;
  logic [IdxW-1:0]     cur_q, cur_d;
  logic [TimeW-1:0]    now_q, now_d;
  logic [FireCntW-1:0] fcnt_q, fcnt_d;
  logic                pend_v_q, pend_v_d;
  logic [IndexW-1:0]   pend_idx_q, pend_idx_d;
  logic                res_v_q, res_v_d;
  out_t                res_q, res_d;
  logic                accept;
  logic                idx_ok;
  logic                hit;

  assign busy   = (state_q != StIdle);
  assign accept = start && !busy;
  assign idx_ok = (9'(item_i.timer_index) < 9'(NUM_TIMERS));
  assign hit    = vld_q && rsp_i.armed && (now_q >= rsp_i.data.due) &&
                  (fcnt_q < FireCntW'(MaxResults));

  // Next state, memory requests and result emission
  always_comb begin
    state_d    = state_q;
    rd_cnt_d   = rd_cnt_q;
    vld_d      = 1'b0;
    cur_d      = cur_q;
    now_d      = now_q;
    fcnt_d     = fcnt_q;
    pend_v_d   = pend_v_q;
    pend_idx_d = pend_idx_q;
    res_v_d    = 1'b0;
    res_d      = res_q;
    req_o      = '0;

    case (state_q)
      StIdle: begin
        if (accept) begin
          case (item_i.command)
            CmdSet: begin
              if (idx_ok) begin
                req_o.wr_en          = 1'b1;
                req_o.wr_addr        = MaxIdxW'(item_i.timer_index);
                req_o.wr_data.period = item_i.interval_ms;
                req_o.wr_data.due    = due_from(item_i.now_ms, item_i.interval_ms);
                req_o.arm_set        = 1'b1;
                req_o.arm_addr       = MaxIdxW'(item_i.timer_index);
              end
            end
            CmdKill: begin
              if (idx_ok) begin
                req_o.arm_clr  = 1'b1;
                req_o.arm_addr = MaxIdxW'(item_i.timer_index);
              end
            end
            CmdTick: begin
              state_d  = StScan;
              rd_cnt_d = '0;
              fcnt_d   = '0;
              pend_v_d = 1'b0;
              now_d    = item_i.now_ms;
            end
            default: ;
          endcase
        end
      end
      StScan: begin
        // Issue the read of the next entry
        if (rd_cnt_q != LastCnt) begin
          req_o.rd_en   = 1'b1;
          req_o.rd_addr = MaxIdxW'(rd_cnt_q);
          cur_d         = IdxW'(rd_cnt_q);
          vld_d         = 1'b1;
          rd_cnt_d      = rd_cnt_q + 1'b1;
        end
        if (vld_q) begin
          // Entry read last cycle: reschedule it if armed, due and within the result limit
          if (hit) begin
            req_o.wr_en          = 1'b1;
            req_o.wr_addr        = MaxIdxW'(cur_q);
            req_o.wr_data.period = rsp_i.data.period;
            req_o.wr_data.due    = due_from(now_q, rsp_i.data.period);
            if (pend_v_q) begin
              res_v_d           = 1'b1;
              res_d.fired_index = pend_idx_q;
              res_d.last_fired  = 1'b0;
            end
            pend_v_d   = 1'b1;
            pend_idx_d = IndexW'(cur_q);
            fcnt_d     = fcnt_q + 1'b1;
          end
        end else if (rd_cnt_q == LastCnt) begin
          // Scan done: the held result is the last one
          if (pend_v_q) begin
            res_v_d           = 1'b1;
            res_d.fired_index = pend_idx_q;
            res_d.last_fired  = 1'b1;
          end
          pend_v_d = 1'b0;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      rd_cnt_q <= '0;
      vld_q    <= 1'b0;
      fcnt_q   <= '0;
      pend_v_q <= 1'b0;
      res_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_cnt_q <= rd_cnt_d;
      vld_q    <= vld_d;
      fcnt_q   <= fcnt_d;
      pend_v_q <= pend_v_d;
      res_v_q  <= res_v_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    now_q      <= now_d;
    pend_idx_q <= pend_idx_d;
    res_q      <= res_d;
  end

  assign result_strobe_o = res_v_q;
  assign result_o        = res_q;

endmodule

FILE: rtl/core/rtt_checker.sv
// Port-level checker of the repeating timer table, bound to the top level.
`include "repeating_timer_table_assert.svh"

module rtt_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input rtt_pkg::in_t  item_i,
  input logic          result_strobe_o,
  input rtt_pkg::out_t result_o
);
  import rtt_pkg::*;

  // A tick always starts a scan
  `RTT_ASSERT_NEXT(a_tick_busy, clk_i, rst_ni, start && !busy && item_i.command == CmdTick, busy)

  // Set and kill complete in their accept cycle
  `RTT_ASSERT_NEXT(a_setkill_idle, clk_i, rst_ni, start && !busy && (item_i.command == CmdSet || item_i.command == CmdKill), !busy)

  // A result shown while idle closes its tick
  `RTT_ASSERT_IMPL(a_idle_last, clk_i, rst_ni, result_strobe_o && !busy, result_o.last_fired)

  // Nothing follows the last result of a tick
  `RTT_ASSERT_NEXT(a_last_gap, clk_i, rst_ni, result_strobe_o && result_o.last_fired, !result_strobe_o)

endmodule

bind repeating_timer_table rtt_checker u_rtt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .item_i         (item_i),
  .result_strobe_o(result_strobe_o),
  .result_o       (result_o)
);
